### rtl/c2e_pkg.sv
// ----------------------------------------------------------------------------
// c2e_pkg
// Types, constants and helpers shared by the cube-face to panorama address unit.
// ----------------------------------------------------------------------------
package c2e_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int MAX_STEPS      = 24;

    localparam int FS_W     = 13;   // face size
    localparam int PW_W     = 15;   // panorama width
    localparam int PH_W     = 14;   // panorama height
    localparam int PIX_W    = 12;   // face column / row
    localparam int NUM_W    = 29;   // dividend of the face coordinate
    localparam int QUO_W    = 18;   // quotient, Q1.16 plus offset
    localparam int DIV_STEPS = QUO_W;
    localparam int CW       = 28;   // CORDIC datapath, Q.24 with headroom
    localparam int CFG_W    = 15;

    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

    // register indexes
    localparam logic [1:0] REG_FACE_SIZE   = 2'd0;
    localparam logic [1:0] REG_PANO_WIDTH  = 2'd1;
    localparam logic [1:0] REG_PANO_HEIGHT = 2'd2;

    // face codes
    localparam logic [2:0] FACE_LEFT   = 3'd0;
    localparam logic [2:0] FACE_RIGHT  = 3'd1;
    localparam logic [2:0] FACE_TOP    = 3'd2;
    localparam logic [2:0] FACE_BOTTOM = 3'd3;
    localparam logic [2:0] FACE_FRONT  = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;

    typedef struct packed {
        logic [2:0]        face;
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
    } in_t;

    typedef struct packed {
        logic [13:0] src_col;
        logic [12:0] src_row;
        logic [26:0] pixel_index;
    } out_t;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TBL [MAX_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // table entry rounded to ab-bit angles
    function automatic logic [31:0] atan_step(input int ab, input int i);
        logic [32:0] t;
        logic [32:0] sh;
        t  = {1'b0, ATAN_TBL[i]} + (33'd1 << (31 - ab));
        sh = t >> (32 - ab);
        return sh[31:0];
    endfunction

endpackage

### rtl/c2e_div_cell.sv
// ----------------------------------------------------------------------------
// c2e_div_cell
// One restoring division step: subtracts the shifted divisor when it fits.
// ----------------------------------------------------------------------------
module c2e_div_cell
    import c2e_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [FS_W-1:0]  fs,
    input  logic [NUM_W-1:0] rem_i,
    input  logic [QUO_W-1:0] quo_i,
    output logic [NUM_W-1:0] rem_o,
    output logic [QUO_W-1:0] quo_o
);
    localparam int DW = FS_W + QUO_W - 1;

    logic [DW-1:0]    dsh;
    logic             fit;
    logic [DW-1:0]    diff;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;

    always_comb begin
        dsh  = DW'(fs) << SHIFT;
        fit  = DW'(rem_i) >= dsh;
        diff = DW'(rem_i) - dsh;
        rem_next = fit ? diff[NUM_W-1:0] : rem_i;
        quo_next = quo_i;
        quo_next[SHIFT] = fit;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rem_o = rem_reg;
    assign quo_o = quo_reg;
endmodule

### rtl/c2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// c2e_cordic_cell
// One vectoring CORDIC iteration: rotates toward y = 0, accumulates angle.
// ----------------------------------------------------------------------------
module c2e_cordic_cell
    import c2e_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int STEP_IDX   = 0
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [CW-1:0]         x_i,
    input  logic signed [CW-1:0]         y_i,
    input  logic signed [ANGLE_BITS+1:0] z_i,
    output logic signed [CW-1:0]         x_o,
    output logic signed [CW-1:0]         y_o,
    output logic signed [ANGLE_BITS+1:0] z_o
);
    localparam int AW = ANGLE_BITS + 2;
    localparam logic [31:0] STEP32 = atan_step(ANGLE_BITS, STEP_IDX);
    localparam logic signed [AW-1:0] STEP = AW'(STEP32);

    logic signed [CW-1:0] xs, ys;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [AW-1:0] z_reg, z_next;

    always_comb begin
        xs = x_i >>> STEP_IDX;
        ys = y_i >>> STEP_IDX;
        if (!y_i[CW-1]) begin
            x_next = x_i + ys;
            y_next = y_i - xs;
            z_next = z_i + STEP;
        end else begin
            x_next = x_i - ys;
            y_next = y_i + xs;
            z_next = z_i - STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;
endmodule

### rtl/cubemap_to_equirect_address_unit.sv
// ----------------------------------------------------------------------------
// cubemap_to_equirect_address_unit
// Maps a cube-face pixel to its nearest equirectangular panorama pixel.
// ----------------------------------------------------------------------------
//  channel | ports                              | payload
//  input   | s_valid, s_ready, s_data           | in_t  (face, col, row)
//  output  | m_valid, m_ready, m_data           | out_t (src_col, src_row, pixel_index)
//  config  | cfg_wr_en, cfg_addr, cfg_wr_data   | face_size, pano_width, pano_height
//
// One transfer per cycle while the output is not stalled; the pipeline is formed
// by two chains of 18 divider cells and the two CORDIC chains.
// Synchronous active-low reset clears the pipeline valids and loads the
// register defaults. A stalled output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module cubemap_to_equirect_address_unit
    import c2e_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wr_data
);
    localparam int AW  = ANGLE_BITS + 2;
    localparam int LAT = DIV_STEPS + 2 * ANGLE_BITS + 6;
    localparam logic signed [AW-1:0] HALF    = AW'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (ANGLE_BITS - 2);
    localparam logic signed [CW-1:0] ONE     = CW'(1) <<< 24;

    // configuration
    logic [FS_W-1:0] face_size_reg;
    logic [PW_W-1:0] pano_width_reg;
    logic [PH_W-1:0] pano_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_size_reg   <= FS_W'(512);
            pano_width_reg  <= PW_W'(4096);
            pano_height_reg <= PH_W'(2048);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FACE_SIZE:   face_size_reg   <= cfg_wr_data[FS_W-1:0];
                REG_PANO_WIDTH:  pano_width_reg  <= cfg_wr_data[PW_W-1:0];
                REG_PANO_HEIGHT: pano_height_reg <= cfg_wr_data[PH_W-1:0];
                default: ;
            endcase
        end
    end

    logic [FS_W-1:0] fs;
    logic [PW_W-1:0] w, w_m1;
    logic [PH_W-1:0] h, h_m1;
    logic [PIX_W-1:0] fs_m1;

    always_comb begin
        fs = face_size_reg;
        if (fs == '0) fs = FS_W'(1);
        else if (fs > FS_W'(4096)) fs = FS_W'(4096);
        w = pano_width_reg;
        if (w == '0) w = PW_W'(1);
        else if (w > PW_W'(16384)) w = PW_W'(16384);
        h = pano_height_reg;
        if (h == '0) h = PH_W'(1);
        else if (h > PH_W'(8192)) h = PH_W'(8192);
        w_m1  = w - PW_W'(1);
        h_m1  = h - PH_W'(1);
        fs_m1 = PIX_W'(fs - FS_W'(1));
    end

    // pipeline control
    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;

    assign en       = !vld_reg[LAT-1] || m_ready;
    assign s_ready  = en;
    assign m_valid  = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // stage A: clamp and form dividends
    logic [PIX_W-1:0] c_cl, r_cl;
    logic [NUM_W-1:0] num_c_next, num_r_next, num_c_reg, num_r_reg;
    logic [2:0]       face_a_reg;

    always_comb begin
        c_cl = (s_data.col > fs_m1) ? fs_m1 : s_data.col;
        r_cl = (s_data.row > fs_m1) ? fs_m1 : s_data.row;
        num_c_next = (NUM_W'({c_cl, 1'b1}) << 16) + NUM_W'(fs >> 1);
        num_r_next = (NUM_W'({r_cl, 1'b1}) << 16) + NUM_W'(fs >> 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_c_reg  <= num_c_next;
            num_r_reg  <= num_r_next;
            face_a_reg <= s_data.face;
        end
    end

    // divider chains, quotient MSB first
    logic [NUM_W-1:0] rem_c [DIV_STEPS+1];
    logic [NUM_W-1:0] rem_r [DIV_STEPS+1];
    logic [QUO_W-1:0] quo_c [DIV_STEPS+1];
    logic [QUO_W-1:0] quo_r [DIV_STEPS+1];
    logic [2:0]       face_sr [DIV_STEPS];

    assign rem_c[0] = num_c_reg;
    assign rem_r[0] = num_r_reg;
    assign quo_c[0] = '0;
    assign quo_r[0] = '0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        c2e_div_cell #(.SHIFT(DIV_STEPS - 1 - k)) u_cell_c (
            .aclk(aclk), .en(en), .fs(fs),
            .rem_i(rem_c[k]), .quo_i(quo_c[k]),
            .rem_o(rem_c[k+1]), .quo_o(quo_c[k+1])
        );
        c2e_div_cell #(.SHIFT(DIV_STEPS - 1 - k)) u_cell_r (
            .aclk(aclk), .en(en), .fs(fs),
            .rem_i(rem_r[k]), .quo_i(quo_r[k]),
            .rem_o(rem_r[k+1]), .quo_o(quo_r[k+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                face_sr[k] <= (k == 0) ? face_a_reg : face_sr[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // stage B: direction vector and pre-rotation for longitude
    logic signed [18:0]   uf, vf;
    logic signed [CW-1:0] u, v, dx, dy, dz;
    logic signed [CW-1:0] x1_next, y1_next, dy_b_reg, x1_reg, y1_reg;
    logic signed [AW-1:0] z1_next, z1_reg;
    logic                 zero_b_reg;

    always_comb begin
        uf = $signed({1'b0, quo_c[DIV_STEPS]}) - 19'sd65536;
        vf = $signed({1'b0, quo_r[DIV_STEPS]}) - 19'sd65536;
        u  = CW'(uf) <<< 8;
        v  = CW'(vf) <<< 8;
        case (face_sr[DIV_STEPS-1])
            FACE_LEFT:   begin dx = -ONE; dy = -v;   dz = u;    end
            FACE_RIGHT:  begin dx = ONE;  dy = -v;   dz = -u;   end
            FACE_TOP:    begin dx = u;    dy = ONE;  dz = v;    end
            FACE_BOTTOM: begin dx = u;    dy = -ONE; dz = -v;   end
            FACE_FRONT:  begin dx = u;    dy = -v;   dz = ONE;  end
            default:     begin dx = -u;   dy = -v;   dz = -ONE; end
        endcase
        if (dx < 0) begin
            x1_next = -dx;
            y1_next = -dz;
            z1_next = (dz < 0) ? -HALF : HALF;
        end else begin
            x1_next = dx;
            y1_next = dz;
            z1_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg     <= x1_next;
            y1_reg     <= y1_next;
            z1_reg     <= z1_next;
            dy_b_reg   <= dy;
            zero_b_reg <= (dx == '0) && (dz == '0);
        end
    end

    // longitude chain
    logic signed [CW-1:0] c1x [ANGLE_BITS+1];
    logic signed [CW-1:0] c1y [ANGLE_BITS+1];
    logic signed [AW-1:0] c1z [ANGLE_BITS+1];
    logic signed [CW-1:0] dy_sr   [ANGLE_BITS];
    logic                 zero_sr [ANGLE_BITS];

    assign c1x[0] = x1_reg;
    assign c1y[0] = y1_reg;
    assign c1z[0] = z1_reg;

    for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_lon
        c2e_cordic_cell #(.ANGLE_BITS(ANGLE_BITS), .STEP_IDX(i)) u_cell (
            .aclk(aclk), .en(en),
            .x_i(c1x[i]), .y_i(c1y[i]), .z_i(c1z[i]),
            .x_o(c1x[i+1]), .y_o(c1y[i+1]), .z_o(c1z[i+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                dy_sr[i]   <= (i == 0) ? dy_b_reg   : dy_sr[(i == 0) ? 0 : i - 1];
                zero_sr[i] <= (i == 0) ? zero_b_reg : zero_sr[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // stage G: remove CORDIC gain from the horizontal length
    logic signed [CW+30:0] gprod;
    logic signed [CW-1:0]  rxy_reg, dy_g_reg;
    logic signed [AW-1:0]  theta_g_reg;

    assign gprod = c1x[ANGLE_BITS] * $signed({1'b0, INV_GAIN_Q30});

    always_ff @(posedge aclk) begin
        if (en) begin
            rxy_reg     <= zero_sr[ANGLE_BITS-1] ? '0 : CW'(gprod >>> 30);
            theta_g_reg <= zero_sr[ANGLE_BITS-1] ? '0 : c1z[ANGLE_BITS];
            dy_g_reg    <= dy_sr[ANGLE_BITS-1];
        end
    end

    // latitude chain, x is never negative here
    logic signed [CW-1:0] c2x [ANGLE_BITS+1];
    logic signed [CW-1:0] c2y [ANGLE_BITS+1];
    logic signed [AW-1:0] c2z [ANGLE_BITS+1];
    logic signed [AW-1:0] theta_sr [ANGLE_BITS];

    assign c2x[0] = rxy_reg;
    assign c2y[0] = dy_g_reg;
    assign c2z[0] = '0;

    for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_lat
        c2e_cordic_cell #(.ANGLE_BITS(ANGLE_BITS), .STEP_IDX(i)) u_cell (
            .aclk(aclk), .en(en),
            .x_i(c2x[i]), .y_i(c2y[i]), .z_i(c2z[i]),
            .x_o(c2x[i+1]), .y_o(c2y[i+1]), .z_o(c2z[i+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                theta_sr[i] <= (i == 0) ? theta_g_reg : theta_sr[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // stage M1: clamp angles and scale
    logic signed [AW-1:0]        eu_s, s_s;
    logic [ANGLE_BITS:0]         eu;
    logic [ANGLE_BITS-1:0]       sv;
    logic [ANGLE_BITS+PW_W:0]    colp_reg;
    logic [ANGLE_BITS+PH_W-1:0]  rowp_reg;

    always_comb begin
        eu_s = theta_sr[ANGLE_BITS-1] + HALF;
        if (eu_s < 0) eu = '0;
        else if (eu_s > (HALF <<< 1)) eu = (ANGLE_BITS+1)'(HALF <<< 1);
        else eu = eu_s[ANGLE_BITS:0];
        s_s = QUARTER - c2z[ANGLE_BITS];
        if (s_s < 0) sv = '0;
        else if (s_s > HALF) sv = HALF[ANGLE_BITS-1:0];
        else sv = s_s[ANGLE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            colp_reg <= (ANGLE_BITS+PW_W+1)'(eu) * (ANGLE_BITS+PW_W+1)'(w_m1);
            rowp_reg <= (ANGLE_BITS+PH_W)'(sv) * (ANGLE_BITS+PH_W)'(h_m1);
        end
    end

    // stage M2: round and clamp
    logic [ANGLE_BITS+PW_W+1:0] colr;
    logic [ANGLE_BITS+PH_W:0]   rowr;
    logic [PW_W:0]              colv;
    logic [PH_W:0]              rowv;
    logic [13:0]                col_reg;
    logic [12:0]                row_reg;

    always_comb begin
        colr = (ANGLE_BITS+PW_W+2)'(colp_reg) + (ANGLE_BITS+PW_W+2)'(HALF);
        rowr = (ANGLE_BITS+PH_W+1)'(rowp_reg) + (ANGLE_BITS+PH_W+1)'(QUARTER);
        colv = (PW_W+1)'(colr >> ANGLE_BITS);
        rowv = (PH_W+1)'(rowr >> (ANGLE_BITS - 1));
        if (colv > (PW_W+1)'(w_m1)) colv = (PW_W+1)'(w_m1);
        if (rowv > (PH_W+1)'(h_m1)) rowv = (PH_W+1)'(h_m1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg <= colv[13:0];
            row_reg <= rowv[12:0];
        end
    end

    // output stage: linear address
    out_t                out_reg;
    logic [PW_W+13:0]    pix;

    assign pix = (PW_W+14)'(row_reg) * (PW_W+14)'(w) + (PW_W+14)'(col_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.src_col     <= col_reg;
            out_reg.src_row     <= row_reg;
            out_reg.pixel_index <= pix[26:0];
        end
    end

    assign m_data = out_reg;
endmodule
